/* sv/bjq_pkg.sv */
// Shared types, constants and helpers for the button and joystick qualifier.
package bjq_pkg;

  // Fixed field widths
  localparam int PORT_W   = 16;
  localparam int TICK_W   = 16;
  localparam int THR_W    = 32;
  localparam int NBTN     = 9;
  localparam int NPIN     = 5;
  localparam int VAL_W    = 8;
  localparam int CFG_AW   = 3;
  localparam int OUT_W    = 72;

  // Reset value of a calibrated maximum, truncated to the converter width
  localparam int AXIS_MAX_RESET = 4095;

  // Port pins that carry the five buttons
  localparam int PIN_BTN0 = 7;
  localparam int PIN_BTN1 = 9;
  localparam int PIN_BTN2 = 8;
  localparam int PIN_BTN3 = 0;
  localparam int PIN_BTN4 = 10;

  // Direction bits in the held mask
  localparam int DIR_RIGHT = 5;
  localparam int DIR_LEFT  = 6;
  localparam int DIR_UP    = 7;
  localparam int DIR_DOWN  = 8;

  // Axis value limits
  localparam logic signed [VAL_W-1:0] DIR_POS = 8'sd100;
  localparam logic signed [VAL_W-1:0] DIR_NEG = -8'sd100;
  localparam logic [VAL_W-2:0]        VAL_MAG_MAX = 7'd127;

  // Configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    REG_X_MIN    = 3'd0,
    REG_X_MAX    = 3'd1,
    REG_X_DZ     = 3'd2,
    REG_Y_MIN    = 3'd3,
    REG_Y_MAX    = 3'd4,
    REG_Y_DZ     = 3'd5,
    REG_HOLD_THR = 3'd6
  } cfg_reg_t;

  // Queue status seen by the producer and the consumer
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Map port pins to button bits 0 to 4
  function automatic logic [NPIN-1:0] btn_from_port(input logic [PORT_W-1:0] port);
    btn_from_port = {port[PIN_BTN4], port[PIN_BTN3], port[PIN_BTN2],
                     port[PIN_BTN1], port[PIN_BTN0]};
  endfunction

endpackage

/* sv/bjq_queue.sv */
// Small register queue between the front end and the back end.
module bjq_queue
  import bjq_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output q_stat_t      stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;

  // Status and head word
  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = mem_r[rd_ptr_r];

  // Store incoming words
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* sv/bjq_front.sv */
// Front end: accepts input words, maps port pins to buttons, fills the queue.
module bjq_front
  import bjq_pkg::*;
#(
  parameter int ADC_BITS = 12
) (
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  input  logic [((PORT_W+2*ADC_BITS+TICK_W+7)/8)*8-1:0] in_tdata,
  input  logic [0:0]                                 in_tuser,
  input  q_stat_t                                    q_stat,
  output logic                                       push,
  output logic [NPIN+2*ADC_BITS+1+TICK_W-1:0]        push_data
);

  logic [PORT_W-1:0]   port;
  logic [ADC_BITS-1:0] raw_x;
  logic [ADC_BITS-1:0] raw_y;
  logic [TICK_W-1:0]   ticks;

  // Split the input word
  assign port  = in_tdata[PORT_W-1:0];
  assign raw_x = in_tdata[PORT_W +: ADC_BITS];
  assign raw_y = in_tdata[PORT_W+ADC_BITS +: ADC_BITS];
  assign ticks = in_tdata[PORT_W+2*ADC_BITS +: TICK_W];

  // Accept whenever the queue has room
  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && !q_stat.full;

  // Pack the classified item: buttons lowest
  assign push_data = {ticks, in_tuser, raw_y, raw_x, btn_from_port(port)};

endmodule

/* sv/bjq_axis.sv */
// One joystick axis: clamp, deadzone and bit-serial scaling divide.
module bjq_axis
  import bjq_pkg::*;
#(
  parameter int ADC_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [ADC_BITS-1:0]     raw,
  input  logic [ADC_BITS-1:0]     lo,
  input  logic [ADC_BITS-1:0]     hi,
  input  logic [ADC_BITS-1:0]     dz,
  output logic                    done,
  output logic signed [VAL_W-1:0] value
);

  localparam int DW = ADC_BITS + 7;
  localparam int CW = $clog2(DW + 1);

  logic                swap;
  logic [ADC_BITS-1:0] l_v;
  logic [ADC_BITS-1:0] h_v;
  logic [ADC_BITS-1:0] c_v;
  logic [ADC_BITS-1:0] mid;
  logic [ADC_BITS-1:0] mag;
  logic [ADC_BITS-1:0] den;
  logic                above;
  logic                below;
  logic                dead;
  logic [DW-1:0]       mag_ext;
  logic [DW-1:0]       dividend;

  logic                run_r;
  logic                fin_r;
  logic                done_r;
  logic [CW-1:0]       cnt_r;
  logic [DW-1:0]       rem_r;
  logic [DW-1:0]       quo_r;
  logic [DW-1:0]       dvs_r;
  logic                neg_r;
  logic                zero_r;
  logic signed [VAL_W-1:0] value_r;

  logic [DW:0]         trial;
  logic                ge;
  logic [DW:0]         diff;
  logic [DW-1:0]       rem_nxt;
  logic [DW-1:0]       quo_nxt;
  logic [VAL_W-2:0]    mag_sat;
  logic signed [VAL_W-1:0] sval;
  logic signed [VAL_W-1:0] value_nxt;

  // Order the limits, clamp and find the midpoint
  always_comb begin
    swap     = (lo > hi);
    l_v      = swap ? hi : lo;
    h_v      = swap ? lo : hi;
    c_v      = (raw < l_v) ? l_v : ((raw > h_v) ? h_v : raw);
    mid      = l_v + ((h_v - l_v) >> 1);
    above    = (c_v > mid);
    below    = (c_v < mid);
    mag      = above ? (c_v - mid) : (mid - c_v);
    dead     = (above || below) && (mag < dz);
    den      = mid - l_v;
    mag_ext  = DW'(mag);
    dividend = (mag_ext << 7) - mag_ext;
  end

  // One restoring divide step
  always_comb begin
    trial   = {rem_r, quo_r[DW-1]};
    ge      = (trial >= {1'b0, dvs_r});
    diff    = trial - {1'b0, dvs_r};
    rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
    quo_nxt = {quo_r[DW-2:0], ge};
  end

  // Saturate, sign and zero the quotient
  always_comb begin
    mag_sat   = (quo_r > DW'(VAL_MAG_MAX)) ? VAL_MAG_MAX : quo_r[VAL_W-2:0];
    sval      = $signed({1'b0, mag_sat});
    value_nxt = zero_r ? '0 : (neg_r ? -sval : sval);
  end

  // Sequence load, divide steps and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        fin_r <= 1'b0;
      end else if (run_r) begin
        if (cnt_r == CW'(1)) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r  <= CW'(DW);
      rem_r  <= '0;
      quo_r  <= dividend;
      dvs_r  <= DW'(den);
      neg_r  <= below ^ swap;
      zero_r <= dead || (den == '0);
    end else if (run_r) begin
      cnt_r <= cnt_r - 1'b1;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end else if (fin_r) begin
      value_r <= value_nxt;
    end
  end

  assign done  = done_r;
  assign value = value_r;

endmodule

/* sv/bjq_back.sv */
// Back end: runs both axes, forms the masks, keeps hold timers, drives results.
module bjq_back
  import bjq_pkg::*;
#(
  parameter int ADC_BITS   = 12,
  parameter int TIMER_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  q_stat_t                             q_stat,
  input  logic [NPIN+2*ADC_BITS+1+TICK_W-1:0] q_data,
  output logic                                q_pop,
  input  logic [ADC_BITS-1:0]                 x_min,
  input  logic [ADC_BITS-1:0]                 x_max,
  input  logic [ADC_BITS-1:0]                 x_dz,
  input  logic [ADC_BITS-1:0]                 y_min,
  input  logic [ADC_BITS-1:0]                 y_max,
  input  logic [ADC_BITS-1:0]                 y_dz,
  input  logic [THR_W-1:0]                    hold_thr,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [OUT_W-1:0]                    out_tdata
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_CALC   = 3'b010,
    ST_COMMIT = 3'b100
  } back_state_t;

  back_state_t state_r, state_nxt;

  logic [NPIN-1:0]     q_btn;
  logic [ADC_BITS-1:0] q_raw_x;
  logic [ADC_BITS-1:0] q_raw_y;
  logic                q_valid;
  logic [TICK_W-1:0]   q_ticks;

  logic [NPIN-1:0]     it_btn_r;
  logic                it_valid_r;
  logic [TICK_W-1:0]   it_ticks_r;

  logic                x_done;
  logic                y_done;
  logic signed [VAL_W-1:0] x_val;
  logic signed [VAL_W-1:0] y_val;

  logic [NBTN-1:0]       now_held_r;
  logic [TIMER_BITS-1:0] timer_r   [NBTN];
  logic [TIMER_BITS-1:0] timer_nxt [NBTN];
  logic signed [VAL_W-1:0] x_reg_r, x_reg_nxt;
  logic signed [VAL_W-1:0] y_reg_r, y_reg_nxt;

  logic [NBTN-1:0]     held;
  logic [NBTN-1:0]     long_m;
  logic [TIMER_BITS:0] sum [NBTN];
  logic                commit;

  logic                out_tvalid_r;
  logic [OUT_W-1:0]    out_tdata_r;
  logic [OUT_W-1:0]    out_tdata_nxt;

  // Unpack the queue head
  assign q_btn   = q_data[NPIN-1:0];
  assign q_raw_x = q_data[NPIN +: ADC_BITS];
  assign q_raw_y = q_data[NPIN+ADC_BITS +: ADC_BITS];
  assign q_valid = q_data[NPIN+2*ADC_BITS];
  assign q_ticks = q_data[NPIN+2*ADC_BITS+1 +: TICK_W];

  assign q_pop  = (state_r == ST_IDLE) && !q_stat.empty;
  assign commit = (state_r == ST_COMMIT) && (!out_tvalid_r || out_tready);

  // Axis units start together and finish together
  bjq_axis #(.ADC_BITS(ADC_BITS)) u_axis_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (q_pop),
    .raw   (q_raw_x),
    .lo    (x_min),
    .hi    (x_max),
    .dz    (x_dz),
    .done  (x_done),
    .value (x_val)
  );

  bjq_axis #(.ADC_BITS(ADC_BITS)) u_axis_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (q_pop),
    .raw   (q_raw_y),
    .lo    (y_min),
    .hi    (y_max),
    .dz    (y_dz),
    .done  (y_done),
    .value (y_val)
  );

  // Sequence one item at a time
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (q_pop) state_nxt = ST_CALC;
      ST_CALC:   if (x_done && y_done) state_nxt = ST_COMMIT;
      ST_COMMIT: if (commit) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Form held bits from buttons and axis directions
  always_comb begin
    held             = '0;
    held[NPIN-1:0]   = it_btn_r;
    held[DIR_RIGHT]  = it_valid_r && (x_val > DIR_POS);
    held[DIR_LEFT]   = it_valid_r && !(x_val > DIR_POS) && (x_val < DIR_NEG);
    held[DIR_UP]     = it_valid_r && (y_val < DIR_NEG);
    held[DIR_DOWN]   = it_valid_r && !(y_val < DIR_NEG) && (y_val > DIR_POS);
    x_reg_nxt        = it_valid_r ? x_val : x_reg_r;
    y_reg_nxt        = it_valid_r ? y_val : y_reg_r;
  end

  // Advance the hold timers with saturation and test the threshold
  always_comb begin
    for (int i = 0; i < NBTN; i++) begin
      sum[i] = {1'b0, timer_r[i]} + (TIMER_BITS + 1)'(it_ticks_r);
      if (held[i]) begin
        timer_nxt[i] = sum[i][TIMER_BITS] ? '1 : sum[i][TIMER_BITS-1:0];
      end else begin
        timer_nxt[i] = '0;
      end
      long_m[i] = held[i] && (THR_W'(timer_nxt[i]) >= hold_thr);
    end
  end

  // Pack the result word: held, pressed, released, long, x, y, ticks
  assign out_tdata_nxt = {4'b0, it_ticks_r, y_reg_nxt, x_reg_nxt, long_m,
                          now_held_r & ~held, held & ~now_held_r, held};

  // Hold item fields while the axes run
  always_ff @(posedge clk) begin
    if (q_pop) begin
      it_btn_r   <= q_btn;
      it_valid_r <= q_valid;
      it_ticks_r <= q_ticks;
    end
    if (commit) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  // State, architectural registers and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      now_held_r   <= '0;
      x_reg_r      <= '0;
      y_reg_r      <= '0;
      for (int i = 0; i < NBTN; i++) begin
        timer_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        out_tvalid_r <= 1'b1;
        now_held_r   <= held;
        x_reg_r      <= x_reg_nxt;
        y_reg_r      <= y_reg_nxt;
        for (int i = 0; i < NBTN; i++) begin
          timer_r[i] <= timer_nxt[i];
        end
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

/* sv/button_joystick_qualifier_core.sv */
// An accepted input passes through the queue, both axis units and the result register.
// The back end takes one item at a time and pops the next only once the last result is
// committed; the bit-serial scaling divider of each axis sets the pace, and both divide in parallel.
// A two-word queue lets inputs be taken while the back end works or the result waits.
// Reset (rst_n low, synchronous) clears held masks, hold timers, axis values, queue and
// output valid, and sets calibration to min 0, max 4095, deadzone 0, threshold 0.
module button_joystick_qualifier_core
  import bjq_pkg::*;
#(
  parameter int ADC_BITS   = 12,
  parameter int TIMER_BITS = 32
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  // Configuration write port
  input  logic                                          cfg_we,
  input  logic [CFG_AW-1:0]                             cfg_addr,
  input  logic [THR_W-1:0]                              cfg_wdata,
  // Input stream
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  // in_tdata: port_sample, raw_x, raw_y, elapsed_ticks, zero pad
  input  logic [((PORT_W+2*ADC_BITS+TICK_W+7)/8)*8-1:0] in_tdata,
  // in_tuser: axes_valid
  input  logic [0:0]                                    in_tuser,
  // Result stream
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  // out_tdata: held_mask, pressed_mask, released_mask, long_held_mask,
  //            x_value, y_value, frame_ticks, zero pad
  output logic [OUT_W-1:0]                              out_tdata
);

  localparam int ITEM_W = NPIN + 2 * ADC_BITS + 1 + TICK_W;

  logic [ADC_BITS-1:0] x_min_r, x_max_r, x_dz_r;
  logic [ADC_BITS-1:0] y_min_r, y_max_r, y_dz_r;
  logic [THR_W-1:0]    hold_thr_r;

  q_stat_t             q_stat;
  logic                q_push;
  logic                q_pop;
  logic [ITEM_W-1:0]   q_wdata;
  logic [ITEM_W-1:0]   q_rdata;

  // Write calibration and threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r    <= '0;
      x_max_r    <= ADC_BITS'(AXIS_MAX_RESET);
      x_dz_r     <= '0;
      y_min_r    <= '0;
      y_max_r    <= ADC_BITS'(AXIS_MAX_RESET);
      y_dz_r     <= '0;
      hold_thr_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_X_MIN:    x_min_r    <= cfg_wdata[ADC_BITS-1:0];
        REG_X_MAX:    x_max_r    <= cfg_wdata[ADC_BITS-1:0];
        REG_X_DZ:     x_dz_r     <= cfg_wdata[ADC_BITS-1:0];
        REG_Y_MIN:    y_min_r    <= cfg_wdata[ADC_BITS-1:0];
        REG_Y_MAX:    y_max_r    <= cfg_wdata[ADC_BITS-1:0];
        REG_Y_DZ:     y_dz_r     <= cfg_wdata[ADC_BITS-1:0];
        REG_HOLD_THR: hold_thr_r <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  bjq_front #(.ADC_BITS(ADC_BITS)) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .push      (q_push),
    .push_data (q_wdata)
  );

  bjq_queue #(.W(ITEM_W), .DEPTH(2)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .stat      (q_stat)
  );

  bjq_back #(.ADC_BITS(ADC_BITS), .TIMER_BITS(TIMER_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .x_min      (x_min_r),
    .x_max      (x_max_r),
    .x_dz       (x_dz_r),
    .y_min      (y_min_r),
    .y_max      (y_max_r),
    .y_dz       (y_dz_r),
    .hold_thr   (hold_thr_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* sv/bjq_checker.sv */
// Port-level checks on the qualifier results, bound to the top level.
module bjq_checker
  import bjq_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  logic [NBTN-1:0] held;
  logic [NBTN-1:0] pressed;
  logic [NBTN-1:0] released;
  logic [NBTN-1:0] long_m;

  assign held     = out_tdata[NBTN-1:0];
  assign pressed  = out_tdata[2*NBTN-1:NBTN];
  assign released = out_tdata[3*NBTN-1:2*NBTN];
  assign long_m   = out_tdata[4*NBTN-1:3*NBTN];

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Edge masks agree with the held mask
  a_edges: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((pressed & ~held) == '0) && ((released & held) == '0))
    else $error("pressed or released inconsistent with held");

  // Long-held bits are held bits
  a_long: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((long_m & ~held) == '0))
    else $error("long-held bit not held");

  // Opposite directions never both held
  a_dirs: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(held[DIR_RIGHT] && held[DIR_LEFT]) &&
                   !(held[DIR_UP] && held[DIR_DOWN]))
    else $error("opposite directions held together");

endmodule

bind button_joystick_qualifier_core bjq_checker u_bjq_checker (.*);
